// ===== sv/assert_macros.svh =====
// assertion helpers used by the port level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define JPQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("job queue check failed");

// clocked assertion that is also checked during reset
`define JPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("job queue check failed");

`endif

// ===== sv/jpq_pkg.sv =====
// ----------------------------------------------------------------------------
// jpq_pkg
// shared types, codes and helpers of the job priority queue table
// ----------------------------------------------------------------------------
package jpq_pkg;

    // default table depth
    localparam int CAPACITY_DEF = 256;

    // field widths
    localparam int FUNC_W  = 3;
    localparam int ID_W    = 31;
    localparam int PREQ_W  = 32;
    localparam int USER_W  = 32;
    localparam int TS_W    = 48;
    localparam int PRI_W   = 16;
    localparam int STAT_W  = 3;
    localparam int QCNT_W  = 9;
    localparam int TOTAL_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int S_DATA_W = 152;
    localparam int M_DATA_W = 112;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_ENQ = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DEQ = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RMW = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RMA = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RST = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CHK = 3'd5;
    localparam logic [FUNC_W-1:0] FN_OWN = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_PERM     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTACT   = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRI = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAEMON  = 2'd2;

    // one table entry as held in memory
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic              run;
        logic [TS_W-1:0]   ts;
        logic [USER_W-1:0] owner;
    } job_entry_t;

    // true when job a sorts strictly before job b
    function automatic logic precedes(job_entry_t a, job_entry_t b);
        logic r;
        if (a.run != b.run) begin
            r = a.run;
        end else if (a.pri != b.pri) begin
            r = (a.pri < b.pri);
        end else if (a.ts != b.ts) begin
            r = (a.ts < b.ts);
        end else begin
            r = (a.id < b.id);
        end
        return r;
    endfunction

endpackage

// ===== sv/jpq_ram.sv =====
// ----------------------------------------------------------------------------
// jpq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module jpq_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/job_priority_queue_table.sv =====
// ----------------------------------------------------------------------------
// job_priority_queue_table
// sorted job table in one ram, driven by a scan / shift / insert sequencer
// ----------------------------------------------------------------------------
// channel   direction  fields (lowest bit first)
// s_axis    in         func, job_number, priority_req, requester, timestamp
// m_axis    out        status, result_job, owner, queued_count, processed_total
// cfg       in         min_priority, max_priority, daemon_user
//
// one transaction at a time; the table ram has one read and one write port,
// and every table step reads an entry, then uses the data.
// enqueue inserts from the back; id lookups scan the entries from the front;
// remove and resort shift the later entries down, and resort then reinserts.
// reset (aresetn low, synchronous) empties the table at once; no clearing pass.
// a result waiting on m_tready holds back only the end of the next transaction.
module job_priority_queue_table #(
    parameter int CAPACITY = jpq_pkg::CAPACITY_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // func, job_number, priority_req, requester, timestamp, zero pad
    input  logic [jpq_pkg::S_DATA_W-1:0]         s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // status, result_job, owner, queued_count, processed_total, zero pad
    output logic [jpq_pkg::M_DATA_W-1:0]         m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_we,
    input  logic [jpq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jpq_pkg::CFG_DAT_W-1:0]        cfg_wdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = $bits(jpq_pkg::job_entry_t);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FIND_RD  = 3'd1;
    localparam logic [2:0] S_FIND_EV  = 3'd2;
    localparam logic [2:0] S_SHIFT_RD = 3'd3;
    localparam logic [2:0] S_SHIFT_WR = 3'd4;
    localparam logic [2:0] S_INS_RD   = 3'd5;
    localparam logic [2:0] S_INS_EV   = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    // input fields
    logic [jpq_pkg::FUNC_W-1:0] in_func;
    logic [jpq_pkg::ID_W-1:0]   in_job;
    logic [jpq_pkg::PREQ_W-1:0] in_pri;
    logic [jpq_pkg::USER_W-1:0] in_req;
    logic [jpq_pkg::TS_W-1:0]   in_ts;

    assign in_func = s_tdata[2:0];
    assign in_job  = s_tdata[33:3];
    assign in_pri  = s_tdata[65:34];
    assign in_req  = s_tdata[97:66];
    assign in_ts   = s_tdata[145:98];

    // registers
    logic [2:0]                  state_reg, state_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [jpq_pkg::ID_W-1:0]    last_id_reg, last_id_next;
    logic [jpq_pkg::TOTAL_W-1:0] done_reg, done_next;
    logic [jpq_pkg::PRI_W-1:0]   min_pri_reg, max_pri_reg;
    logic [jpq_pkg::USER_W-1:0]  daemon_reg;
    jpq_pkg::job_entry_t         cur_reg, cur_next;
    logic                        resort_reg, resort_next;
    logic [jpq_pkg::FUNC_W-1:0]  op_reg, op_next;
    logic [jpq_pkg::ID_W-1:0]    jn_reg, jn_next;
    logic [jpq_pkg::USER_W-1:0]  req_reg, req_next;
    logic [jpq_pkg::STAT_W-1:0]  st_reg, st_next;
    logic [jpq_pkg::ID_W-1:0]    rjob_reg, rjob_next;
    logic [jpq_pkg::USER_W-1:0]  own_reg, own_next;
    logic                        m_valid_reg, m_valid_next;
    logic [jpq_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    // ram ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [EW-1:0]       ram_wdata, ram_rdata;
    jpq_pkg::job_entry_t rd_ent;

    assign rd_ent = jpq_pkg::job_entry_t'(ram_rdata);

    jpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // helpers
    logic [CW-1:0]              idx_inc, idx_dec;
    logic                       admin_req, perm_ok, id_hit, found;
    logic signed [jpq_pkg::PREQ_W-1:0] pri_s, pri_hi, pri_clamp;
    logic [jpq_pkg::ID_W-1:0]   new_id;

    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign admin_req = (req_reg == '0) || (req_reg == daemon_reg);
    assign perm_ok   = admin_req || (req_reg == rd_ent.owner);
    assign id_hit    = (rd_ent.id == jn_reg);

    // priority clamp: max first, then min
    assign pri_s     = $signed(in_pri);
    assign pri_hi    = (pri_s > $signed({16'b0, max_pri_reg})) ?
                       $signed({16'b0, max_pri_reg}) : pri_s;
    assign pri_clamp = (pri_hi < $signed({16'b0, min_pri_reg})) ?
                       $signed({16'b0, min_pri_reg}) : pri_hi;

    // next job id, skipping zero
    assign new_id = ((last_id_reg + 1'b1) == '0) ? jpq_pkg::ID_W'(1) : last_id_reg + 1'b1;

    // match rule of the lookup scan
    always_comb begin
        case (op_reg)
            jpq_pkg::FN_DEQ: found = !rd_ent.run;
            jpq_pkg::FN_RMA: found = rd_ent.run && id_hit;
            default:         found = id_hit;
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        last_id_next = last_id_reg;
        done_next    = done_reg;
        cur_next     = cur_reg;
        resort_next  = resort_reg;
        op_next      = op_reg;
        jn_next      = jn_reg;
        req_next     = req_reg;
        st_next      = st_reg;
        rjob_next    = rjob_reg;
        own_next     = own_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[AW-1:0];
        ram_wdata    = cur_reg;
        ram_raddr    = idx_reg[AW-1:0];
        s_tready     = (state_reg == S_IDLE);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next   = in_func;
                    jn_next   = in_job;
                    req_next  = in_req;
                    st_next   = jpq_pkg::ST_NOTFOUND;
                    rjob_next = '0;
                    own_next  = '0;
                    idx_next  = '0;
                    case (in_func)
                        jpq_pkg::FN_ENQ: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                st_next    = jpq_pkg::ST_FULL;
                                state_next = S_RESP;
                            end else begin
                                cur_next.id    = new_id;
                                cur_next.pri   = pri_clamp[jpq_pkg::PRI_W-1:0];
                                cur_next.run   = 1'b0;
                                cur_next.ts    = in_ts;
                                cur_next.owner = in_req;
                                last_id_next   = new_id;
                                rjob_next      = new_id;
                                st_next        = jpq_pkg::ST_OK;
                                idx_next       = count_reg;
                                state_next     = S_INS_RD;
                            end
                        end
                        jpq_pkg::FN_DEQ, jpq_pkg::FN_RMW, jpq_pkg::FN_RMA,
                        jpq_pkg::FN_CHK, jpq_pkg::FN_OWN: begin
                            state_next = S_FIND_RD;
                        end
                        jpq_pkg::FN_RST: begin
                            if ((in_req == '0) || (in_req == daemon_reg)) begin
                                state_next = S_FIND_RD;
                            end else begin
                                st_next    = jpq_pkg::ST_PERM;
                                state_next = S_RESP;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // lookup scan from the front
            S_FIND_RD: begin
                if (idx_reg == count_reg) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_FIND_EV;
                end
            end

            S_FIND_EV: begin
                if (!found) begin
                    idx_next   = idx_inc;
                    state_next = S_FIND_RD;
                end else begin
                    state_next = S_RESP;
                    case (op_reg)
                        jpq_pkg::FN_DEQ: begin
                            cur_next     = rd_ent;
                            cur_next.run = 1'b1;
                            rjob_next    = rd_ent.id;
                            st_next      = jpq_pkg::ST_OK;
                            count_next   = count_reg - 1'b1;
                            resort_next  = 1'b1;
                            state_next   = S_SHIFT_RD;
                        end
                        jpq_pkg::FN_RMW, jpq_pkg::FN_RMA: begin
                            if (rd_ent.run && (op_reg == jpq_pkg::FN_RMW)) begin
                                st_next = jpq_pkg::ST_PERM;
                            end else if (perm_ok) begin
                                st_next     = jpq_pkg::ST_OK;
                                count_next  = count_reg - 1'b1;
                                done_next   = done_reg + jpq_pkg::TOTAL_W'(rd_ent.run);
                                resort_next = 1'b0;
                                state_next  = S_SHIFT_RD;
                            end else begin
                                st_next = jpq_pkg::ST_PERM;
                            end
                        end
                        jpq_pkg::FN_RST: begin
                            if (rd_ent.run) begin
                                cur_next     = rd_ent;
                                cur_next.run = 1'b0;
                                st_next      = jpq_pkg::ST_OK;
                                count_next   = count_reg - 1'b1;
                                resort_next  = 1'b1;
                                state_next   = S_SHIFT_RD;
                            end else begin
                                st_next = jpq_pkg::ST_NOTACT;
                            end
                        end
                        jpq_pkg::FN_CHK: begin
                            st_next = perm_ok ? jpq_pkg::ST_OK : jpq_pkg::ST_PERM;
                        end
                        jpq_pkg::FN_OWN: begin
                            own_next = rd_ent.owner;
                            st_next  = jpq_pkg::ST_OK;
                        end
                        default: begin
                            st_next = jpq_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
            end

            // close the gap: entry i+1 moves down to i
            S_SHIFT_RD: begin
                ram_raddr = idx_inc[AW-1:0];
                if (idx_reg >= count_reg) begin
                    if (resort_reg) begin
                        idx_next   = count_reg;
                        state_next = S_INS_RD;
                    end else begin
                        state_next = S_RESP;
                    end
                end else begin
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_inc;
                state_next = S_SHIFT_RD;
            end

            // insertion from the back: later entries move up one place
            S_INS_RD: begin
                ram_raddr = idx_dec[AW-1:0];
                if (idx_reg == '0) begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end else begin
                    state_next = S_INS_EV;
                end
            end

            S_INS_EV: begin
                ram_we = 1'b1;
                if (jpq_pkg::precedes(cur_reg, rd_ent)) begin
                    ram_wdata  = ram_rdata;
                    idx_next   = idx_dec;
                    state_next = S_INS_RD;
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end
            end

            // hand the result to the output register
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, done_reg, jpq_pkg::QCNT_W'(count_reg),
                                    own_reg, rjob_reg, st_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            last_id_reg <= '0;
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            last_id_reg <= last_id_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        resort_reg <= resort_next;
        op_reg     <= op_next;
        jn_reg     <= jn_next;
        req_reg    <= req_next;
        st_reg     <= st_next;
        rjob_reg   <= rjob_next;
        own_reg    <= own_next;
        m_data_reg <= m_data_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pri_reg <= '0;
            max_pri_reg <= '1;
            daemon_reg  <= jpq_pkg::USER_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                jpq_pkg::CFG_MIN_PRI: min_pri_reg <= cfg_wdata[jpq_pkg::PRI_W-1:0];
                jpq_pkg::CFG_MAX_PRI: max_pri_reg <= cfg_wdata[jpq_pkg::PRI_W-1:0];
                jpq_pkg::CFG_DAEMON:  daemon_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== sv/jpq_checker.sv =====
// ----------------------------------------------------------------------------
// jpq_checker
// port level checks of the job priority queue table, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jpq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [jpq_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    logic [jpq_pkg::STAT_W-1:0] st;
    assign st = m_tdata[2:0];

    // a stalled result transaction holds
    `JPQ_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // status is one of the defined codes
    `JPQ_ASSERT(a_status, aclk, aresetn, m_tvalid |-> (st <= jpq_pkg::ST_FULL))

    // only a successful operation reports a job id
    `JPQ_ASSERT(a_job, aclk, aresetn, m_tvalid && (st != jpq_pkg::ST_OK) |-> (m_tdata[33:3] == '0))

    // only a successful operation reports an owner
    `JPQ_ASSERT(a_own, aclk, aresetn, m_tvalid && (st != jpq_pkg::ST_OK) |-> (m_tdata[65:34] == '0))

endmodule

bind job_priority_queue_table jpq_checker u_jpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== verif/jpq_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpq_table_checker
// watches the job table channels, keeps its own sorted copy of the table and
// compares every reply with the predicted one, in order of arrival
// ----------------------------------------------------------------------------
module jpq_table_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [jpq_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [jpq_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_we,
    input  logic [jpq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jpq_pkg::CFG_DAT_W-1:0] cfg_wdata,
    output int                            fail_count,
    output int                            replies_pending
);
    import jpq_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    job;
        logic [USER_W-1:0]  owner;
        logic [QCNT_W-1:0]  queued;
        logic [TOTAL_W-1:0] processed;
    } job_reply_t;

    // shadow of the table and its counters
    job_entry_t         shadow_jobs [DEPTH];
    int                 shadow_count;
    logic [ID_W-1:0]    last_issued_id;
    logic [TOTAL_W-1:0] finished_jobs;
    logic [PRI_W-1:0]   floor_pri;
    logic [PRI_W-1:0]   ceil_pri;
    logic [USER_W-1:0]  admin_user;

    job_reply_t expected_replies [$];

    assign replies_pending = expected_replies.size();

    // ordering: running first, then priority, time, id
    function automatic bit goes_ahead(job_entry_t a, job_entry_t b);
        if (a.run != b.run) return a.run;
        if (a.pri != b.pri) return a.pri < b.pri;
        if (a.ts != b.ts) return a.ts < b.ts;
        return a.id < b.id;
    endfunction

    function automatic bit is_admin(logic [USER_W-1:0] u);
        return (u == '0) || (u == admin_user);
    endfunction

    function automatic int locate_job(logic [ID_W-1:0] id);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_jobs[i].id == id) return i;
        return -1;
    endfunction

    task automatic place_job(job_entry_t e);
        int pos;
        pos = 0;
        while (pos < shadow_count && !goes_ahead(e, shadow_jobs[pos])) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_jobs[i] = shadow_jobs[i-1];
        shadow_jobs[pos] = e;
        shadow_count++;
    endtask

    task automatic take_out(int p);
        shadow_count--;
        for (int i = p; i < shadow_count; i++) shadow_jobs[i] = shadow_jobs[i+1];
    endtask

    task automatic retire_job(int p);
        if (shadow_jobs[p].run) finished_jobs++;
        take_out(p);
    endtask

    task automatic reorder_job(int p);
        job_entry_t e;
        e = shadow_jobs[p];
        take_out(p);
        place_job(e);
    endtask

    // work out the reply for one command and update the shadow table
    task automatic predict_reply(logic [S_DATA_W-1:0] d, output job_reply_t r);
        logic [FUNC_W-1:0] fn;
        logic [ID_W-1:0]   jn;
        logic signed [PREQ_W-1:0] preq;
        logic [USER_W-1:0] who;
        logic [TS_W-1:0]   ts;
        longint            pr;
        job_entry_t        e;
        int                p;
        fn   = d[2:0];
        jn   = d[33:3];
        preq = d[65:34];
        who  = d[97:66];
        ts   = d[145:98];
        r.status = ST_NOTFOUND;
        r.job    = '0;
        r.owner  = '0;
        case (fn)
            FN_ENQ: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pr = preq;
                    if (pr > longint'(ceil_pri)) pr = ceil_pri;
                    if (pr < longint'(floor_pri)) pr = floor_pri;
                    last_issued_id = last_issued_id + 1'b1;
                    if (last_issued_id == '0) last_issued_id = 1;
                    e.id = last_issued_id;
                    e.pri = pr[PRI_W-1:0];
                    e.run = 1'b0;
                    e.ts = ts;
                    e.owner = who;
                    place_job(e);
                    r.status = ST_OK;
                    r.job = last_issued_id;
                end
            end
            FN_DEQ: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (!shadow_jobs[i].run) begin
                        shadow_jobs[i].run = 1'b1;
                        r.job = shadow_jobs[i].id;
                        reorder_job(i);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            FN_RMW: begin
                p = locate_job(jn);
                if (p >= 0) begin
                    if (shadow_jobs[p].run) begin
                        r.status = ST_PERM;
                    end else if (is_admin(who) || who == shadow_jobs[p].owner) begin
                        retire_job(p);
                        r.status = ST_OK;
                    end else begin
                        r.status = ST_PERM;
                    end
                end
            end
            FN_RMA: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_jobs[i].run && shadow_jobs[i].id == jn) begin
                        if (is_admin(who) || who == shadow_jobs[i].owner) begin
                            retire_job(i);
                            r.status = ST_OK;
                        end else begin
                            r.status = ST_PERM;
                        end
                        break;
                    end
                end
            end
            FN_RST: begin
                if (!is_admin(who)) begin
                    r.status = ST_PERM;
                end else begin
                    p = locate_job(jn);
                    if (p >= 0) begin
                        if (shadow_jobs[p].run) begin
                            shadow_jobs[p].run = 1'b0;
                            reorder_job(p);
                            r.status = ST_OK;
                        end else begin
                            r.status = ST_NOTACT;
                        end
                    end
                end
            end
            FN_CHK: begin
                p = locate_job(jn);
                if (p >= 0)
                    r.status = (is_admin(who) || who == shadow_jobs[p].owner) ? ST_OK : ST_PERM;
            end
            FN_OWN: begin
                p = locate_job(jn);
                if (p >= 0) begin
                    r.owner = shadow_jobs[p].owner;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.queued = shadow_count[QCNT_W-1:0];
        r.processed = finished_jobs;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: reply %s mismatch: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    // follow register writes, commands and replies
    always @(posedge aclk) begin
        job_reply_t want;
        if (!aresetn) begin
            shadow_count = 0;
            last_issued_id = '0;
            finished_jobs = '0;
            floor_pri = '0;
            ceil_pri = '1;
            admin_user = 1;
            expected_replies.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MIN_PRI: floor_pri = cfg_wdata[PRI_W-1:0];
                    CFG_MAX_PRI: ceil_pri = cfg_wdata[PRI_W-1:0];
                    CFG_DAEMON:  admin_user = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: reply with no command outstanding", $time);
                    fail_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_tdata[2:0] != want.status)
                        report_mismatch("status", m_tdata[2:0], want.status);
                    if (m_tdata[33:3] != want.job)
                        report_mismatch("result_job", m_tdata[33:3], want.job);
                    if (m_tdata[65:34] != want.owner)
                        report_mismatch("owner", m_tdata[65:34], want.owner);
                    if (m_tdata[74:66] != want.queued)
                        report_mismatch("queued_count", m_tdata[74:66], want.queued);
                    if (m_tdata[106:75] != want.processed)
                        report_mismatch("processed_total", m_tdata[106:75], want.processed);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_reply(s_tdata, want);
                expected_replies.push_back(want);
            end
        end
    end

endmodule

// ===== verif/tb_job_priority_queue_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_job_priority_queue_table
// drives job commands and register settings into the job table: a directed
// opening, a fill to capacity under receiver back-pressure, a drain, then
// random command mixes under several priority limits and admin users
// ----------------------------------------------------------------------------
module tb_job_priority_queue_table;
    import jpq_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    logic                  aclk;
    logic                  aresetn;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_wdata;

    int          fail_count;
    int          replies_pending;
    int          cycle_count;
    int          hold_seq;
    bit          calm;
    int unsigned enq_sent;
    logic [USER_W-1:0] cur_daemon;

    job_priority_queue_table u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    jpq_table_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .replies_pending(replies_pending)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_job_priority_queue_table NOT OK");
            $finish;
        end
    end

    // result side: random stalls, long hold-off on request
    initial begin
        int seen_seq;
        int hold_left;
        seen_seq = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_seq != seen_seq) begin
                seen_seq = hold_seq;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // offer one command and wait for its transaction
    task automatic send_cmd(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] jn,
                            logic [PREQ_W-1:0] pr, logic [USER_W-1:0] who,
                            logic [TS_W-1:0] ts);
        s_tdata  <= {6'd0, ts, who, pr, jn, fn};
        s_tvalid <= 1'b1;
        if (fn == FN_ENQ) enq_sent++;
        do @(posedge aclk); while (!s_tready);
        if (!calm && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // stop offering and let every reply come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (replies_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // write all three registers, block idle
    task automatic set_limits(logic [PRI_W-1:0] lo, logic [PRI_W-1:0] hi,
                              logic [USER_W-1:0] dmn);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MIN_PRI;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= CFG_MAX_PRI;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= CFG_DAEMON;
        cfg_wdata <= dmn;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_daemon = dmn;
        @(posedge aclk);
    endtask

    function automatic logic [PREQ_W-1:0] pick_priority();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom_range(0, 300) - 50;
        endcase
    endfunction

    function automatic logic [USER_W-1:0] pick_user();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return cur_daemon;
            2: return $urandom;
            default: return $urandom_range(2, 5);
        endcase
    endfunction

    function automatic logic [TS_W-1:0] pick_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return $urandom_range(0, 3) == 0 ? w[TS_W-1:0] : TS_W'($urandom_range(0, 20));
    endfunction

    // job id near the recently issued ones, sometimes anything
    function automatic logic [ID_W-1:0] pick_id();
        int unsigned lo;
        if ($urandom_range(0, 9) == 0) return ID_W'($urandom);
        lo = (enq_sent > 40) ? enq_sent - 40 : 0;
        return ID_W'($urandom_range(lo, enq_sent + 2));
    endfunction

    task automatic random_cmds(int count);
        int w;
        logic [FUNC_W-1:0] fn;
        for (int k = 0; k < count; k++) begin
            w = $urandom_range(0, 99);
            if (w < 25)      fn = FN_ENQ;
            else if (w < 43) fn = FN_DEQ;
            else if (w < 58) fn = FN_RMW;
            else if (w < 76) fn = FN_RMA;
            else if (w < 84) fn = FN_RST;
            else if (w < 91) fn = FN_CHK;
            else if (w < 98) fn = FN_OWN;
            else             fn = 3'd7;
            send_cmd(fn, pick_id(), pick_priority(), pick_user(), pick_stamp());
        end
    endtask

    // main sequence
    initial begin
        aresetn = 1'b0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MIN_PRI;
        cfg_wdata = '0;
        hold_seq = 0;
        calm = 1'b0;
        enq_sent = 0;
        cur_daemon = 1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening on an empty table
        set_limits(16'd10, 16'd60000, 32'd1);
        send_cmd(FN_DEQ, '0, '0, '0, '0);
        send_cmd(3'd7, '1, '1, '1, '1);
        send_cmd(FN_CHK, 31'd1, '0, '0, '0);
        send_cmd(FN_OWN, 31'd1, '0, '0, '0);
        send_cmd(FN_RMW, '1, '0, '0, '0);
        send_cmd(FN_RST, 31'd9, '0, 32'd7, '0);
        send_cmd(FN_ENQ, '0, 32'h8000_0000, 32'd3, '1);
        send_cmd(FN_ENQ, '1, 32'h7fff_ffff, '1, '0);
        send_cmd(FN_ENQ, '0, 32'd100, 32'd4, 48'd5);
        send_cmd(FN_ENQ, '0, 32'd100, 32'd4, 48'd5);
        send_cmd(FN_RST, 31'd3, '0, 32'd1, '0);
        send_cmd(FN_DEQ, '0, '0, 32'd9, '0);
        send_cmd(FN_RMW, 31'd1, '0, '0, '0);
        send_cmd(FN_RMA, 31'd3, '0, '0, '0);
        send_cmd(FN_CHK, 31'd3, '0, 32'd9, '0);
        send_cmd(FN_CHK, 31'd3, '0, 32'd4, '0);
        send_cmd(FN_OWN, 31'd2, '0, 32'd9, '0);
        send_cmd(FN_RMA, 31'd1, '0, 32'd9, '0);
        send_cmd(FN_RMA, 31'd1, '0, 32'd3, '0);
        send_cmd(FN_DEQ, '0, '0, '0, '0);
        send_cmd(FN_RST, 31'd3, '0, '0, '0);
        send_cmd(FN_RMW, 31'd2, '0, 32'd1, '0);
        wait_drained();

        // fill past capacity while the result side holds off
        set_limits(16'd0, 16'hffff, 32'd1);
        calm = 1'b1;
        hold_seq++;
        for (int k = 0; k < CAPACITY_DEF + 4; k++)
            send_cmd(FN_ENQ, pick_id(), pick_priority(), pick_user(), pick_stamp());
        calm = 1'b0;
        repeat (3) send_cmd(FN_DEQ, '0, '0, pick_user(), '0);
        wait_drained();

        // drain by id as user zero
        for (int unsigned id = 1; id <= enq_sent + 1; id++)
            send_cmd(FN_RMW, ID_W'(id), '0, '0, '0);
        wait_drained();

        // random mixes under several settings, inverted and extreme limits among them
        set_limits(16'd100, 16'd200, 32'd7);
        random_cmds(100);
        wait_drained();
        set_limits(16'd500, 16'd300, 32'hffff_ffff);
        random_cmds(100);
        wait_drained();
        set_limits(16'd0, 16'd0, 32'd0);
        calm = 1'b1;
        random_cmds(80);
        calm = 1'b0;
        wait_drained();
        set_limits(16'hffff, 16'hffff, 32'd5);
        random_cmds(100);
        wait_drained();
        set_limits(16'd1000, 16'd60000, 32'd2);
        random_cmds(110);
        wait_drained();
        set_limits(16'd0, 16'hffff, 32'd3);
        random_cmds(110);
        wait_drained();
        repeat (50) @(posedge aclk);

        if (fail_count == 0 && replies_pending == 0) begin
            $display("tb_job_priority_queue_table OK");
        end else begin
            $display("tb_job_priority_queue_table NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/jpq_pkg.sv
sv/jpq_ram.sv
sv/job_priority_queue_table.sv
sv/jpq_checker.sv
verif/jpq_table_checker.sv
verif/tb_job_priority_queue_table.sv
